>>> sv/lsh_sig_pkg.sv
// Shared types and constants for the hyperplane signature block.
// Holds the token that runs down the cell chain and the result record
// that follows it. No dependencies.
package lsh_sig_pkg;

  // Frame and signature limits
  localparam int DIM_MAX   = 64;
  localparam int BITS_MAX  = 64;
  localparam int BYTE_BITS = 8;

  // Field and register widths
  localparam int VALUE_W   = 16;
  localparam int BIT_IDX_W = 6;
  localparam int DIM_IDX_W = 6;
  localparam int CFG_LEN_W = 7;
  localparam int THR_W     = 37;
  localparam int CFG_W     = 37;
  localparam int CFG_IDX_W = 2;
  localparam int SIG_W     = 64;

  // Derived widths
  localparam int IDX_W      = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;
  localparam int CNT_W      = $clog2(DIM_MAX + 1);
  localparam int LEN_W      = ((CNT_W > CFG_LEN_W) ? CNT_W : CFG_LEN_W) + 1;
  localparam int PROD_W     = 2 * VALUE_W;
  localparam int ACC_W      = PROD_W + $clog2(DIM_MAX);
  localparam int NORM_RAW_W = 2 * VALUE_W - 1 + $clog2(DIM_MAX);
  localparam int NORM_W     = (NORM_RAW_W > THR_W) ? NORM_RAW_W : THR_W;

  // Result queue
  localparam int OUT_DEPTH = 8;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIM_IN_USE  = 2'd0,
    CFG_BITS_IN_USE = 2'd1,
    CFG_NORM_CHK_EN = 2'd2,
    CFG_NORM_THR    = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    ACT_LOAD    = 1'b0,
    ACT_FEATURE = 1'b1
  } act_e;

  // Work item handed from cell to cell: a weight load or a feature element
  typedef struct packed {
    logic                 valid;
    logic                 load;
    logic [BIT_IDX_W-1:0] bit_rel;
    logic [IDX_W-1:0]     idx;
    logic [VALUE_W-1:0]   value;
    logic                 last;
  } tok_t;

  // Signature under construction, trailing the last element of a frame
  typedef struct packed {
    logic                valid;
    logic                flag;
    logic [BITS_MAX-1:0] sig;
  } res_t;

  // Finished result as queued for the output
  typedef struct packed {
    logic                flag;
    logic [BITS_MAX-1:0] sig;
  } out_t;

endpackage

>>> sv/lsh_sig_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module lsh_sig_ram #(
  parameter int Width = 16,
  parameter int Depth = 64,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write or read one word per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/lsh_sig_cell.sv
// One hyperplane cell: weight RAM for its dimensions, multiply, accumulate.
// Depends on lsh_sig_pkg and lsh_sig_ram.
module lsh_sig_cell
  import lsh_sig_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  tok_t tok_i,
  output tok_t tok_o,
  input  res_t res_i,
  output res_t res_o
);

  logic                      ram_we;
  logic                      ram_re;
  logic [VALUE_W-1:0]        w_rdata;
  tok_t                      tok_d, tok_q;
  logic signed [PROD_W-1:0]  prod_d, prod_q;
  logic                      el_valid_q;
  logic                      last_q;
  logic signed [ACC_W-1:0]   sum;
  logic signed [ACC_W-1:0]   acc_q;
  logic                      sig_bit;
  res_t                      res_d, res_q;

  // Load into this cell when the relative hyperplane index reaches zero
  assign ram_we = tok_i.valid && tok_i.load && (tok_i.bit_rel == '0);
  assign ram_re = tok_i.valid && !tok_i.load;

  lsh_sig_ram #(
    .Width(VALUE_W),
    .Depth(DIM_MAX)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .re_i   (ram_re),
    .addr_i (tok_i.idx),
    .wdata_i(tok_i.value),
    .rdata_o(w_rdata)
  );

  // Hand the transaction to the next cell, one hyperplane further on
  always_comb begin
    tok_d         = tok_i;
    tok_d.bit_rel = tok_i.bit_rel - 1'b1;
  end

  // Multiply the feature element by this cell's weight
  assign prod_d = $signed(tok_q.value) * $signed(w_rdata);

  // Running projection; its sign gives this cell's signature bit
  assign sum     = acc_q + ACC_W'(prod_q);
  assign sig_bit = ~sum[ACC_W-1];

  // Shift the bit in at the top; after the whole row it sits at its index
  always_comb begin
    res_d       = res_i;
    res_d.sig   = {sig_bit, res_i.sig[BITS_MAX-1:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q      <= '0;
      el_valid_q <= 1'b0;
      last_q     <= 1'b0;
      acc_q      <= '0;
      res_q      <= '0;
    end else begin
      tok_q      <= tok_d;
      el_valid_q <= tok_q.valid && !tok_q.load;
      last_q     <= tok_q.last;
      res_q      <= res_d;
      if (el_valid_q) begin
        acc_q <= last_q ? '0 : sum;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign tok_o = tok_q;
  assign res_o = res_q;

  // The signature record must meet the frame's last product in this cell
  a_res_aligned : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_i.valid |-> (el_valid_q && last_q))
    else $error("signature record out of step with last product");

  // The projection clears once a frame ends
  a_acc_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (el_valid_q && last_q) |=> (acc_q == '0))
    else $error("projection not cleared at end of frame");

endmodule

>>> sv/lsh_sig_fifo.sv
// Result queue between the free-running cell row and the output channel.
// Depends on lsh_sig_pkg.
module lsh_sig_fifo
  import lsh_sig_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  out_t push_data_i,
  input  logic pop_i,
  output logic valid_o,
  output out_t data_o
);

  out_t                 mem_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr_q;
  logic [OUT_PTR_W-1:0] rd_ptr_q;
  logic [OUT_CNT_W-1:0] cnt_q;

  // Store pushed results
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  // Credits upstream must keep the queue from overflowing
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> ((cnt_q != OUT_CNT_W'(OUT_DEPTH)) || pop_i))
    else $error("result queue overflow");

endmodule

>>> sv/lsh_hyperplane_signature.sv
// Random-hyperplane LSH signature block: config registers, frame counter,
// squared norm, row of hyperplane cells and result queue.
// Depends on lsh_sig_pkg, lsh_sig_cell and lsh_sig_fifo.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o): action_i = 0 loads weight_value_i
//   for hyperplane weight_bit_i and dimension weight_dim_i; action_i = 1
//   delivers the next feature element of the frame. Every transaction runs
//   down a row of BITS_MAX cells, one cell per cycle, so loads and elements
//   keep their order and a load affects only the elements behind it.
//   Output channel (out_valid_o/out_ready_i): one signature per frame, after
//   dim_in_use elements (0 acts as 1, above DIM_MAX as DIM_MAX), with
//   below_threshold_o set and a zero signature when the enabled norm check fails.
//   Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i at once.
// Throughput:
//   One transaction per cycle is accepted while in_ready_o is high. A signature
//   trails its frame's last element down the row into the result queue. Up to
//   OUT_DEPTH (8) frames may be in flight or queued; in_ready_o drops while eight
//   are pending, so frames shorter than about 9 elements are limited by the row length.
// Reset: clears frame state, pending count and queue; registers go to their
//   defaults. The weight memories are not cleared and must be loaded.
// Stall: results wait in the queue; the row never stops.
module lsh_hyperplane_signature
  import lsh_sig_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  // input channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 action_i,
  input  logic [BIT_IDX_W-1:0] weight_bit_i,
  input  logic [DIM_IDX_W-1:0] weight_dim_i,
  input  logic signed [VALUE_W-1:0] weight_value_i,
  input  logic signed [VALUE_W-1:0] feature_value_i,
  // output channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [SIG_W-1:0]     signature_o,
  output logic                 below_threshold_o
);

  logic [CFG_LEN_W-1:0]  dim_q;
  logic [CFG_LEN_W-1:0]  bits_q;
  logic                  chk_en_q;
  logic [THR_W-1:0]      thr_q;

  logic                  in_acc;
  logic                  is_el;
  logic                  load_ok;
  logic [LEN_W-1:0]      dim_eff;
  logic                  el_last;
  logic [CNT_W-1:0]      cnt_q;
  tok_t                  tok_d, tok0_q;

  logic signed [PROD_W-1:0] sq_full;
  logic [PROD_W-1:0]     sq_q;
  logic                  sq_vld_q;
  logic                  sq_last_q;
  logic [NORM_W-1:0]     norm_q;
  logic [NORM_W-1:0]     norm_sum;
  logic                  below;
  res_t                  res_d, res0_q;

  tok_t                  tok_chain [BITS_MAX+1];
  res_t                  res_chain [BITS_MAX+1];
  tok_t                  tok_tail;
  res_t                  res_tail;

  logic [CFG_LEN_W-1:0]  nbits_cap;
  logic [CFG_LEN_W-1:0]  nbits;
  logic [BITS_MAX-1:0]   sig_mask;
  out_t                  push_data;
  logic                  out_pop;
  out_t                  out_data;
  logic [OUT_CNT_W-1:0]  pend_q;
  logic                  pend_inc;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q    <= CFG_LEN_W'(39);
      bits_q   <= CFG_LEN_W'(32);
      chk_en_q <= 1'b0;
      thr_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_DIM_IN_USE:  dim_q    <= cfg_wdata_i[CFG_LEN_W-1:0];
        CFG_BITS_IN_USE: bits_q   <= cfg_wdata_i[CFG_LEN_W-1:0];
        CFG_NORM_CHK_EN: chk_en_q <= cfg_wdata_i[0];
        CFG_NORM_THR:    thr_q    <= cfg_wdata_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Accept a transaction while fewer than OUT_DEPTH frames are pending
  assign in_ready_o = (pend_q != OUT_CNT_W'(OUT_DEPTH));
  assign in_acc     = in_valid_i && in_ready_o;
  assign is_el      = (act_e'(action_i) == ACT_FEATURE);
  assign load_ok    = (int'(weight_bit_i) < BITS_MAX) && (int'(weight_dim_i) < DIM_MAX);

  // Clamp the frame length and detect the frame's last element
  always_comb begin
    dim_eff = LEN_W'(dim_q);
    if (dim_q == '0) begin
      dim_eff = LEN_W'(1);
    end else if (LEN_W'(dim_q) > LEN_W'(DIM_MAX)) begin
      dim_eff = LEN_W'(DIM_MAX);
    end
  end
  assign el_last = (LEN_W'(cnt_q) + LEN_W'(1)) >= dim_eff;

  // Build the head token of the row
  always_comb begin
    tok_d = '0;
    if (in_acc) begin
      tok_d.valid   = is_el || load_ok;
      tok_d.load    = !is_el;
      tok_d.bit_rel = weight_bit_i;
      tok_d.idx     = is_el ? cnt_q[IDX_W-1:0] : IDX_W'(weight_dim_i);
      tok_d.value   = is_el ? feature_value_i : weight_value_i;
      tok_d.last    = is_el && el_last;
    end
  end

  // Square the element, then fold it into the running norm
  assign sq_full  = $signed(tok0_q.value) * $signed(tok0_q.value);
  assign norm_sum = norm_q + NORM_W'(sq_q);
  assign below    = chk_en_q && (norm_sum < NORM_W'(thr_q));

  always_comb begin
    res_d       = '0;
    res_d.valid = sq_vld_q && sq_last_q;
    res_d.flag  = below;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      tok0_q    <= '0;
      sq_vld_q  <= 1'b0;
      sq_last_q <= 1'b0;
      norm_q    <= '0;
      res0_q    <= '0;
    end else begin
      if (in_acc && is_el) begin
        cnt_q <= el_last ? '0 : cnt_q + 1'b1;
      end
      tok0_q    <= tok_d;
      sq_vld_q  <= tok0_q.valid && !tok0_q.load;
      sq_last_q <= tok0_q.last;
      if (sq_vld_q) begin
        norm_q <= sq_last_q ? '0 : norm_sum;
      end
      res0_q    <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q <= sq_full;
  end

  // Row of hyperplane cells
  assign tok_chain[0] = tok0_q;
  assign res_chain[0] = res0_q;

  for (genvar k = 0; k < BITS_MAX; k++) begin : g_cell
    lsh_sig_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .tok_i (tok_chain[k]),
      .tok_o (tok_chain[k+1]),
      .res_i (res_chain[k]),
      .res_o (res_chain[k+1])
    );
  end

  assign tok_tail = tok_chain[BITS_MAX];
  assign res_tail = res_chain[BITS_MAX];

  // Keep whole bytes of the signature, up to BITS_MAX bits
  always_comb begin
    nbits_cap = (bits_q > CFG_LEN_W'(BITS_MAX)) ? CFG_LEN_W'(BITS_MAX) : bits_q;
    nbits     = nbits_cap & ~CFG_LEN_W'(BYTE_BITS - 1);
    for (int k = 0; k < BITS_MAX; k++) begin
      sig_mask[k] = (CFG_LEN_W'(k) < nbits);
    end
  end

  always_comb begin
    push_data.flag = res_tail.flag;
    push_data.sig  = res_tail.flag ? '0 : (res_tail.sig & sig_mask);
  end

  assign out_pop = out_valid_o && out_ready_i;

  lsh_sig_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res_tail.valid),
    .push_data_i(push_data),
    .pop_i      (out_pop),
    .valid_o    (out_valid_o),
    .data_o     (out_data)
  );

  always_comb begin
    signature_o                 = '0;
    signature_o[BITS_MAX-1:0]   = out_data.sig;
  end
  assign below_threshold_o = out_data.flag;

  // Count frames accepted but not yet delivered
  assign pend_inc = in_acc && is_el && el_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      case ({pend_inc, out_pop})
        2'b10:   pend_q <= pend_q + 1'b1;
        2'b01:   pend_q <= pend_q - 1'b1;
        default: pend_q <= pend_q;
      endcase
    end
  end

  // A signature leaves the row trailing its last element by the head's sq_vld_q and res0_q registers
  a_tail_aligned : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_tail.valid |-> $past(tok_tail.valid && !tok_tail.load && tok_tail.last, 2))
    else $error("signature left the row out of step with its frame");

  // The element counter restarts after the last element of a frame
  a_cnt_wrap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_el && el_last) |=> (cnt_q == '0))
    else $error("element counter did not restart");

  // Pending frames never exceed the queue depth
  a_pend_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= OUT_CNT_W'(OUT_DEPTH))
    else $error("pending frame count out of range");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for lsh_hyperplane_signature: directed table, then random frames.
// Depends on lsh_sig_pkg and the block's RTL; predicts signatures in plain SystemVerilog.
module tb_top;
  import lsh_sig_pkg::*;

  typedef enum logic [1:0] {
    ROW_LOAD,
    ROW_FEAT,
    ROW_CFG
  } row_kind_e;

  // One row of the directed table; val carries weight, feature or register data
  typedef struct packed {
    row_kind_e   kind;
    cfg_reg_e    cfg_sel;
    logic [5:0]  wb;
    logic [5:0]  wd;
    logic [36:0] val;
    int          reps;
    logic        typed;
    logic [63:0] t_sig;
    logic        t_flag;
  } stim_row_t;

  localparam int N_ROWS  = 32;
  localparam int SETTLE  = BITS_MAX + 16;
  localparam int N_PHASE = 22;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_idx_i = CFG_DIM_IN_USE;
  logic [CFG_W-1:0]         cfg_wdata_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic                     action_i = ACT_LOAD;
  logic [BIT_IDX_W-1:0]     weight_bit_i = '0;
  logic [DIM_IDX_W-1:0]     weight_dim_i = '0;
  logic signed [VALUE_W-1:0] weight_value_i = '0;
  logic signed [VALUE_W-1:0] feature_value_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b1;
  logic [SIG_W-1:0]         signature_o;
  logic                     below_threshold_o;

  // Predictor state: weights, per-hyperplane sums, squared norm, element count
  logic signed [15:0] wt_mem [BITS_MAX*DIM_MAX];
  longint             frame_acc [BITS_MAX];
  longint unsigned    norm_acc = 0;
  int unsigned        elem_cnt = 0;
  logic [6:0]         dim_reg = 7'd39;
  logic [6:0]         bits_reg = 7'd32;
  logic               chk_reg = 1'b0;
  logic [36:0]        thr_reg = '0;

  out_t      sig_expect_q [$];
  int        err_cnt = 0;
  int        idle_pct = 0;
  int        stall_pct = 0;
  logic      calm = 1'b0;
  stim_row_t dir_tab [N_ROWS];

  lsh_hyperplane_signature u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .action_i         (action_i),
    .weight_bit_i     (weight_bit_i),
    .weight_dim_i     (weight_dim_i),
    .weight_value_i   (weight_value_i),
    .feature_value_i  (feature_value_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .signature_o      (signature_o),
    .below_threshold_o(below_threshold_o)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Advance the predicted frame by one accepted transaction
  task automatic sig_predict(input act_e act, input logic [5:0] wb, input logic [5:0] wd,
                             input logic signed [15:0] wv, input logic signed [15:0] fv,
                             output logic hit, output out_t res);
    int unsigned flen;
    int unsigned nb;
    longint      x;
    hit = 1'b0;
    res = '0;
    if (act == ACT_LOAD) begin
      wt_mem[{wb, wd}] = wv;
    end else begin
      flen = dim_reg;
      if (flen < 1) flen = 1;
      if (flen > DIM_MAX) flen = DIM_MAX;
      x = fv;
      if (elem_cnt < DIM_MAX) begin
        for (int k = 0; k < BITS_MAX; k++) begin
          frame_acc[k] += x * longint'(wt_mem[k*DIM_MAX + elem_cnt]);
        end
      end
      norm_acc += longint'(x * x);
      elem_cnt++;
      if (elem_cnt >= flen) begin
        hit = 1'b1;
        if (chk_reg && norm_acc < thr_reg) begin
          res.flag = 1'b1;
        end else begin
          nb = bits_reg;
          if (nb > BITS_MAX) nb = BITS_MAX;
          nb -= nb % BYTE_BITS;
          for (int k = 0; k < nb; k++) begin
            if (frame_acc[k] >= 0) res.sig[k] = 1'b1;
          end
        end
        // clear the frame
        for (int k = 0; k < BITS_MAX; k++) frame_acc[k] = 0;
        norm_acc = 0;
        elem_cnt = 0;
      end
    end
  endtask

  // Present one transaction, hold until accepted, then queue its expected result
  task automatic drive_item(input act_e act, input logic [5:0] wb, input logic [5:0] wd,
                            input logic [15:0] wv, input logic [15:0] fv,
                            input logic typed, input logic [63:0] t_sig, input logic t_flag);
    logic hit;
    out_t res;
    in_valid_i      <= 1'b1;
    action_i        <= act;
    weight_bit_i    <= wb;
    weight_dim_i    <= wd;
    weight_value_i  <= wv;
    feature_value_i <= fv;
    do @(posedge clk_i); while (!in_ready_o);
    sig_predict(act, wb, wd, wv, fv, hit, res);
    if (typed) begin
      res.sig  = t_sig;
      res.flag = t_flag;
    end
    if (hit || typed) sig_expect_q.push_back(res);
    // random idle burst on the input side
    if (!calm && $urandom_range(1, 100) <= idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  endtask

  // Drop valid, wait for every pending signature, then let the cell row drain
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sig_expect_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic cfg_write(input cfg_reg_e sel, input logic [CFG_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= sel;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (sel)
      CFG_DIM_IN_USE:  dim_reg = data[6:0];
      CFG_BITS_IN_USE: bits_reg = data[6:0];
      CFG_NORM_CHK_EN: chk_reg = data[0];
      CFG_NORM_THR:    thr_reg = data[36:0];
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Output side: random stall bursts, none near the end
  initial begin
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(1, 100) <= stall_pct) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin : result_check
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (sig_expect_q.size() == 0) begin
        $error("unexpected result: signature %h below_threshold %b",
               signature_o, below_threshold_o);
        err_cnt++;
      end else begin
        want = sig_expect_q.pop_front();
        if (signature_o !== want.sig) begin
          $error("signature: expected %h, got %h", want.sig, signature_o);
          err_cnt++;
        end
        if (below_threshold_o !== want.flag) begin
          $error("below_threshold: expected %b, got %b", want.flag, below_threshold_o);
          err_cnt++;
        end
      end
    end
  end

  // Hard limit on run length
  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    int              n_items;
    int unsigned     eff;
    logic [6:0]      dim_v;
    logic [6:0]      bits_v;
    logic [36:0]     thr_v;
    logic [15:0]     fv;
    longint unsigned t;

    for (int k = 0; k < BITS_MAX; k++) frame_acc[k] = 0;

    dir_tab = '{
      // reset defaults: 39 elements, 32 bits, zero features give ones in the low half
      '{ROW_FEAT, CFG_DIM_IN_USE,  6'd0,  6'd0, 37'h0000,  39, 1'b1, 64'h0000_0000_FFFF_FFFF, 1'b0},
      '{ROW_CFG,  CFG_DIM_IN_USE,  6'd0,  6'd0, 37'd1,      1, 1'b0, 64'h0, 1'b0},
      '{ROW_CFG,  CFG_BITS_IN_USE, 6'd0,  6'd0, 37'd64,     1, 1'b0, 64'h0, 1'b0},
      '{ROW_FEAT, CFG_DIM_IN_USE,  6'd0,  6'd0, 37'h0000,   1, 1'b1, {64{1'b1}}, 1'b0},
      '{ROW_FEAT, CFG_DIM_IN_USE,  6'd0,  6'd0, 37'h7FFF,   1, 1'b0, 64'h0, 1'b0},
      '{ROW_FEAT, CFG_DIM_IN_USE,  6'd0,  6'd0, 37'h8000,   1, 1'b0, 64'h0, 1'b0},
      // extreme weights on the first and last hyperplane
      '{ROW_LOAD, CFG_DIM_IN_USE,  6'd0,  6'd0, 37'h7FFF,   1, 1'b0, 64'h0, 1'b0},
      '{ROW_LOAD, CFG_DIM_IN_USE,  6'd63, 6'd0, 37'h8000,   1, 1'b0, 64'h0, 1'b0},
      '{ROW_FEAT, CFG_DIM_IN_USE,  6'd0,  6'd0, 37'h8000,   1, 1'b0, 64'h0, 1'b0},
      '{ROW_FEAT, CFG_DIM_IN_USE,  6'd0,  6'd0, 37'h7FFF,   1, 1'b0, 64'h0, 1'b0},
      // bit count above the maximum, not a multiple of eight, below eight
      '{ROW_CFG,  CFG_BITS_IN_USE, 6'd0,  6'd0, 37'd127,    1, 1'b0, 64'h0, 1'b0},
      '{ROW_FEAT, CFG_DIM_IN_USE,  6'd0,  6'd0, 37'h0000,   1, 1'b1, {64{1'b1}}, 1'b0},
      '{ROW_CFG,  CFG_BITS_IN_USE, 6'd0,  6'd0, 37'd13,     1, 1'b0, 64'h0, 1'b0},
      '{ROW_FEAT, CFG_DIM_IN_USE,  6'd0,  6'd0, 37'h0000,   1, 1'b1, 64'hFF, 1'b0},
      '{ROW_CFG,  CFG_BITS_IN_USE, 6'd0,  6'd0, 37'd7,      1, 1'b0, 64'h0, 1'b0},
      '{ROW_FEAT, CFG_DIM_IN_USE,  6'd0,  6'd0, 37'h0000,   1, 1'b1, 64'h0, 1'b0},
      // zero frame length acts as one element
      '{ROW_CFG,  CFG_DIM_IN_USE,  6'd0,  6'd0, 37'd0,      1, 1'b0, 64'h0, 1'b0},
      '{ROW_CFG,  CFG_BITS_IN_USE, 6'd0,  6'd0, 37'd64,     1, 1'b0, 64'h0, 1'b0},
      '{ROW_FEAT, CFG_DIM_IN_USE,  6'd0,  6'd0, 37'h0000,   1, 1'b1, {64{1'b1}}, 1'b0},
      // norm check: skipped frame, a frame just at the threshold, then a full-scale frame under the largest threshold
      '{ROW_CFG,  CFG_NORM_CHK_EN, 6'd0,  6'd0, 37'd1,      1, 1'b0, 64'h0, 1'b0},
      '{ROW_CFG,  CFG_NORM_THR,    6'd0,  6'd0, 37'd1,      1, 1'b0, 64'h0, 1'b0},
      '{ROW_FEAT, CFG_DIM_IN_USE,  6'd0,  6'd0, 37'h0000,   1, 1'b1, 64'h0, 1'b1},
      '{ROW_FEAT, CFG_DIM_IN_USE,  6'd0,  6'd0, 37'h0001,   1, 1'b0, 64'h0, 1'b0},
      '{ROW_CFG,  CFG_NORM_THR,    6'd0,  6'd0, {37{1'b1}}, 1, 1'b0, 64'h0, 1'b0},
      '{ROW_FEAT, CFG_DIM_IN_USE,  6'd0,  6'd0, 37'h8000,   1, 1'b1, 64'h0, 1'b1},
      '{ROW_CFG,  CFG_NORM_CHK_EN, 6'd0,  6'd0, 37'd0,      1, 1'b0, 64'h0, 1'b0},
      // weight load mid-frame, then frame length lowered below the count
      '{ROW_CFG,  CFG_DIM_IN_USE,  6'd0,  6'd0, 37'd8,      1, 1'b0, 64'h0, 1'b0},
      '{ROW_FEAT, CFG_DIM_IN_USE,  6'd0,  6'd0, 37'h0123,   3, 1'b0, 64'h0, 1'b0},
      '{ROW_LOAD, CFG_DIM_IN_USE,  6'd5,  6'd3, 37'h4000,   1, 1'b0, 64'h0, 1'b0},
      '{ROW_FEAT, CFG_DIM_IN_USE,  6'd0,  6'd0, 37'hFF00,   2, 1'b0, 64'h0, 1'b0},
      '{ROW_CFG,  CFG_DIM_IN_USE,  6'd0,  6'd0, 37'd3,      1, 1'b0, 64'h0, 1'b0},
      '{ROW_FEAT, CFG_DIM_IN_USE,  6'd0,  6'd0, 37'h0042,   1, 1'b0, 64'h0, 1'b0}
    };

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill the whole weight table so no unwritten entry is ever read
    for (int b = 0; b < BITS_MAX; b++) begin
      for (int d = 0; d < DIM_MAX; d++) begin
        drive_item(ACT_LOAD, b[5:0], d[5:0], 16'($urandom), 16'($urandom), 1'b0, 64'h0, 1'b0);
      end
    end

    // Directed table
    idle_pct  = 15;
    stall_pct = 10;
    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        settle();
        cfg_write(dir_tab[i].cfg_sel, dir_tab[i].val);
      end else begin
        for (int j = 0; j < dir_tab[i].reps; j++) begin
          drive_item(act_e'(dir_tab[i].kind == ROW_LOAD ? ACT_LOAD : ACT_FEATURE),
                     dir_tab[i].wb, dir_tab[i].wd, dir_tab[i].val[15:0], dir_tab[i].val[15:0],
                     dir_tab[i].typed && (j == dir_tab[i].reps - 1),
                     dir_tab[i].t_sig, dir_tab[i].t_flag);
        end
      end
    end

    // Random phases: new settings, then a stream of frames with a few weight loads
    for (int ph = 0; ph < N_PHASE; ph++) begin
      settle();
      calm = (ph >= N_PHASE - 4);
      case ($urandom_range(0, 2))
        0:       idle_pct = 0;
        1:       idle_pct = 10;
        default: idle_pct = 30;
      endcase
      case ($urandom_range(0, 2))
        0:       stall_pct = 0;
        1:       stall_pct = 10;
        default: stall_pct = 30;
      endcase
      case ($urandom_range(0, 9))
        0:       dim_v = 7'd0;
        1:       dim_v = 7'd1;
        2:       dim_v = 7'd64;
        3:       dim_v = 7'd127;
        default: dim_v = 7'($urandom_range(1, 12));
      endcase
      case ($urandom_range(0, 5))
        0:       bits_v = 7'd8;
        1:       bits_v = 7'd64;
        2:       bits_v = 7'd127;
        3:       bits_v = 7'($urandom_range(0, 7));
        default: bits_v = 7'($urandom_range(0, 127));
      endcase
      eff = (dim_v == 0) ? 1 : ((dim_v > DIM_MAX) ? DIM_MAX : dim_v);
      case ($urandom_range(0, 5))
        0:       thr_v = '0;
        1:       thr_v = {37{1'b1}};
        default: begin
          t     = longint'($urandom_range(0, 1023)) * eff * 64'd1048576;
          thr_v = t[36:0];
        end
      endcase
      cfg_write(CFG_DIM_IN_USE, 37'(dim_v));
      cfg_write(CFG_BITS_IN_USE, 37'(bits_v));
      cfg_write(CFG_NORM_CHK_EN, 37'($urandom_range(0, 1)));
      cfg_write(CFG_NORM_THR, thr_v);

      n_items = $urandom_range(70, 110);
      for (int i = 0; i < n_items; i++) begin
        case ($urandom_range(0, 9))
          0:       fv = 16'h8000;
          1:       fv = 16'h7FFF;
          2:       fv = 16'h0000;
          3, 4:    fv = 16'($signed($urandom_range(0, 255)) - 128);
          default: fv = 16'($urandom);
        endcase
        if ($urandom_range(0, 11) == 0) begin
          drive_item(ACT_LOAD, 6'($urandom), 6'($urandom), 16'($urandom), 16'($urandom),
                     1'b0, 64'h0, 1'b0);
        end else begin
          drive_item(ACT_FEATURE, 6'($urandom), 6'($urandom), 16'($urandom), fv,
                     1'b0, 64'h0, 1'b0);
        end
      end
    end

    // Wait out every pending signature and the row latency
    settle();
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
